// ===== rtl/imu_binary_packet_receiver_assert.svh =====
// Assertion macros for the inertial sensor reply receiver.
// Has no dependencies; the top level includes it inside its module body.
`ifndef IMU_BINARY_PACKET_RECEIVER_ASSERT_SVH
`define IMU_BINARY_PACKET_RECEIVER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define IBPR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ibpr assertion failed");

// Next-cycle implication, checked on every rising edge out of reset.
`define IBPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ibpr assertion failed");

`endif

// ===== rtl/ibpr_pkg.sv =====
// Shared constants, types and the CRC-16 step for the inertial sensor reply receiver.
// No dependencies; used by ibpr_scale and imu_binary_packet_receiver.
`timescale 1ns / 1ps

package ibpr_pkg;

	// Frame layout.
	localparam int FRAME_BYTES   = 30;
	localparam int PAYLOAD_FIRST = 4;
	localparam int PAYLOAD_BYTES = 24;
	localparam int PAYLOAD_WORDS = PAYLOAD_BYTES / 4;
	localparam int NUM_AXES      = 6;

	localparam logic [7:0] SYNC_VALUE = 8'hFA;

	// Register reset values.
	localparam logic [31:0] GYRO_GAIN_RST  = 32'd75098726;
	localparam logic [31:0] ACCEL_GAIN_RST = 32'd26722120;

	// Register indexes on the configuration port.
	localparam logic CFG_GYRO_GAIN  = 1'b0;
	localparam logic CFG_ACCEL_GAIN = 1'b1;

	// Biased exponent at which the product needs no shift (127 + 23 + 16).
	localparam logic [7:0] EXP_SHIFT_BASE = 8'd166;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_GOOD     = 2'd0,
		ST_SYNC_ERR = 2'd1,
		ST_CRC_ERR  = 2'd2
	} status_t;

	// Control from the top level to the scaling unit.
	typedef struct packed {
		logic adv;   // pipeline advances this cycle
		logic zero;  // force a zero result (error word)
	} scl_ctl_t;

	// One byte of CRC-16, polynomial 0x1021, MSB first.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = {crc_in[7:0], crc_in[15:8]};
		c = c ^ {8'h00, b};
		c = c ^ {12'h000, c[7:4]};
		c = c ^ {c[3:0], 12'h000};
		c = c ^ {3'b000, c[7:0], 5'b00000};
		return c;
	endfunction

endpackage

// ===== rtl/ibpr_scale.sv =====
// Two-stage scaling unit: IEEE single times an unsigned Q16.16 gain,
// truncated toward zero and saturated to int16. Depends on ibpr_pkg.
`timescale 1ns / 1ps

module ibpr_scale import ibpr_pkg::*; (
	input  logic               clk,
	input  scl_ctl_t           ctl,
	input  logic [31:0]        word,
	input  logic [31:0]        gain,
	output logic signed [15:0] value
);

	logic [7:0]  ex_raw;
	logic [22:0] frac;
	logic [23:0] man;
	logic [7:0]  ex_eff;
	logic        spec;
	logic [15:0] spec_val;

	logic [55:0] prod_s2;
	logic [7:0]  ex_s2;
	logic        neg_s2;
	logic        spec_s2;
	logic [15:0] spec_val_s2;

	logic [7:0]  lsh;
	logic [7:0]  rsh;
	logic [31:0] mag_l;
	logic [55:0] mag;
	logic [15:0] res;

	// Unpack the float; NaN, infinity and forced zeros are settled here.
	always_comb begin
		ex_raw = word[30:23];
		frac   = word[22:0];
		if (ex_raw == 8'h00) begin
			man    = {1'b0, frac};
			ex_eff = 8'd1;
		end else begin
			man    = {1'b1, frac};
			ex_eff = ex_raw;
		end
		spec = ctl.zero || (ex_raw == 8'hFF);
		if (ctl.zero || frac != 23'd0 || gain == 32'd0) begin
			spec_val = 16'h0000;
		end else if (word[31]) begin
			spec_val = 16'h8000;
		end else begin
			spec_val = 16'h7FFF;
		end
	end

	// Product register.
	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			prod_s2     <= 56'(man) * 56'(gain);
			ex_s2       <= ex_eff;
			neg_s2      <= word[31];
			spec_s2     <= spec;
			spec_val_s2 <= spec_val;
		end
	end

	// Align by the exponent, then saturate to int16.
	always_comb begin
		lsh   = ex_s2 - EXP_SHIFT_BASE;
		rsh   = EXP_SHIFT_BASE - ex_s2;
		mag_l = 32'(prod_s2[15:0]) << lsh[3:0];
		if (prod_s2 == 56'd0) begin
			mag = 56'd0;
		end else if (ex_s2 >= EXP_SHIFT_BASE) begin
			if (prod_s2[55:16] != 40'd0 || lsh >= 8'd16) begin
				mag = 56'h10000;
			end else begin
				mag = {24'd0, mag_l};
			end
		end else if (rsh >= 8'd64) begin
			mag = 56'd0;
		end else begin
			mag = prod_s2 >> rsh[5:0];
		end

		if (neg_s2) begin
			if (mag >= 56'h8000) begin
				res = 16'h8000;
			end else begin
				res = 16'h0000 - mag[15:0];
			end
		end else begin
			if (mag > 56'h7FFF) begin
				res = 16'h7FFF;
			end else begin
				res = mag[15:0];
			end
		end

		if (spec_s2) begin
			value = spec_val_s2;
		end else begin
			value = res;
		end
	end

endmodule

// ===== rtl/imu_binary_packet_receiver.sv =====
// Top level of the inertial sensor reply receiver: deframer, CRC check, payload store,
// result sequencer and output register. Depends on ibpr_pkg, ibpr_scale and the assert header.
`timescale 1ns / 1ps

// Takes one byte per cycle of a 30-byte sensor reply unless held off; a byte with tuser set
// opens a frame and must be the sync byte 0xFA, and a CRC-16 (0x1021, init 0) over bytes 1
// to 29 must end at zero. After byte 29 a good frame gives six words, axis 0 to 5 (gyro
// x,y,z, then accel x,y,z), each the stored float times its gain register truncated and
// saturated to int16; a bad frame gives one word with axis and value zero and the error in
// tuser. Words leave through a three-stage pipeline (store read, multiply, align and
// saturate into the output register), one per cycle while the sink is ready. A good burst
// issues six words and an error burst one; issue waits while the sink holds off. During a
// burst, bytes at position 4 or later of an open frame are held off, and so is a frame
// start that arrives then; the sync byte and the three header bytes of the next frame are
// still taken.
module imu_binary_packet_receiver import ibpr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	// Byte input.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] frame_start
	// Result output.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [2:0] axis, [18:3] value, [23:19] zero
	output logic [1:0]  m_axis_tuser,   // [1:0] status
	output logic        m_axis_tlast
);

	logic [31:0] gyro_gain_q;
	logic [31:0] accel_gain_q;

	logic [4:0]  count_q;
	logic        in_frame_q;
	logic [15:0] crc_q;
	logic        sync_good_q;

	logic        emit_q;
	logic [2:0]  k_q;
	logic        err_q;
	status_t     err_status_q;

	logic [31:0] words_q [PAYLOAD_WORDS];

	logic        in_acc;
	logic [15:0] crc_next;
	logic [4:0]  pidx;
	logic        pwrite;
	logic        frame_end;

	logic        en;
	logic        issue;
	logic [2:0]  raddr;

	logic        v_s1;
	logic [2:0]  axis_s1;
	logic        last_s1;
	status_t     status_s1;
	logic        zero_s1;
	logic [31:0] rd_s1;

	logic        v_s2;
	logic [2:0]  axis_s2;
	logic        last_s2;
	status_t     status_s2;

	logic               out_valid_q;
	logic [2:0]         out_axis_q;
	logic signed [15:0] out_value_q;
	status_t            out_status_q;
	logic               out_last_q;

	scl_ctl_t           scl_ctl;
	logic [31:0]        gain_s1;
	logic signed [15:0] value_s2;

	logic               out_err;
	logic               out_good_last;

	// Configuration is always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gyro_gain_q  <= GYRO_GAIN_RST;
			accel_gain_q <= ACCEL_GAIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_GYRO_GAIN) begin
				gyro_gain_q <= cfg_data;
			end else begin
				accel_gain_q <= cfg_data;
			end
		end
	end

	// Input acceptance: bytes from position 4 on of an open frame wait while a burst is still reading the store.
	assign s_axis_tready = !emit_q || !(in_frame_q && count_q >= 5'(PAYLOAD_FIRST));
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	assign crc_next  = crc_byte(crc_q, s_axis_tdata);
	assign pidx      = count_q - 5'(PAYLOAD_FIRST);
	assign pwrite    = in_acc && !s_axis_tuser && in_frame_q
		&& count_q >= 5'(PAYLOAD_FIRST) && count_q < 5'(PAYLOAD_FIRST + PAYLOAD_BYTES);
	assign frame_end = in_acc && !s_axis_tuser && in_frame_q
		&& count_q == 5'(FRAME_BYTES - 1);

	// Frame tracking and CRC.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			in_frame_q  <= 1'b0;
			crc_q       <= '0;
			sync_good_q <= 1'b0;
		end else if (in_acc) begin
			if (s_axis_tuser) begin
				in_frame_q  <= 1'b1;
				count_q     <= 5'd1;
				crc_q       <= '0;
				sync_good_q <= (s_axis_tdata == SYNC_VALUE);
			end else if (in_frame_q) begin
				crc_q <= crc_next;
				if (frame_end) begin
					in_frame_q <= 1'b0;
					count_q    <= '0;
				end else begin
					count_q <= count_q + 5'd1;
				end
			end
		end
	end

	// Payload store: six words, written one byte lane at a time, read registered.
	always_ff @(posedge clk) begin
		if (pwrite) begin
			words_q[pidx[4:2]][{pidx[1:0], 3'b000} +: 8] <= s_axis_tdata;
		end
		if (issue) begin
			rd_s1 <= words_q[raddr];
		end
	end

	// Pipeline moves when the output register is free or being emptied.
	assign en    = !out_valid_q || m_axis_tready;
	assign issue = emit_q && en;

	// Gyro words sit behind the accel words in the store.
	always_comb begin
		if (k_q < 3'd3) begin
			raddr = k_q + 3'd3;
		end else begin
			raddr = k_q - 3'd3;
		end
	end

	// Result sequencer: one word per cycle of a burst while the pipeline moves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q       <= 1'b0;
			k_q          <= '0;
			err_q        <= 1'b0;
			err_status_q <= ST_GOOD;
		end else if (frame_end) begin
			emit_q <= 1'b1;
			k_q    <= '0;
			err_q  <= !sync_good_q || crc_next != 16'h0000;
			if (!sync_good_q) begin
				err_status_q <= ST_SYNC_ERR;
			end else if (crc_next != 16'h0000) begin
				err_status_q <= ST_CRC_ERR;
			end else begin
				err_status_q <= ST_GOOD;
			end
		end else if (issue) begin
			if (err_q || k_q == 3'(NUM_AXES - 1)) begin
				emit_q <= 1'b0;
				k_q    <= '0;
			end else begin
				k_q <= k_q + 3'd1;
			end
		end
	end

	// Stage 1 and stage 2 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (issue) begin
				axis_s1   <= err_q ? 3'd0 : k_q;
				last_s1   <= err_q || k_q == 3'(NUM_AXES - 1);
				status_s1 <= err_status_q;
				zero_s1   <= err_q;
			end
			axis_s2   <= axis_s1;
			last_s2   <= last_s1;
			status_s2 <= status_s1;
		end
	end

	// Scaling unit.
	assign gain_s1      = (axis_s1 < 3'd3) ? gyro_gain_q : accel_gain_q;
	assign scl_ctl.adv  = en;
	assign scl_ctl.zero = zero_s1;

	ibpr_scale u_scale (
		.clk   (clk),
		.ctl   (scl_ctl),
		.word  (rd_s1),
		.gain  (gain_s1),
		.value (value_s2)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_axis_q   <= axis_s2;
			out_value_q  <= value_s2;
			out_status_q <= status_s2;
			out_last_q   <= last_s2;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b00000, out_value_q, out_axis_q};
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tlast  = out_last_q;

	// Kinds of output word watched by the checks below.
	assign out_err       = m_axis_tvalid && m_axis_tuser != ST_GOOD;
	assign out_good_last = m_axis_tvalid && m_axis_tuser == ST_GOOD && m_axis_tlast;

	`include "imu_binary_packet_receiver_assert.svh"

	// An error word is a lone, zeroed, final word.
	`IBPR_ASSERT_IMPLY(a_err_word, clk, arst_n, out_err, m_axis_tlast && m_axis_tdata == 24'd0)

	// A good burst ends on the last accel axis.
	`IBPR_ASSERT_IMPLY(a_good_last, clk, arst_n, out_good_last, m_axis_tdata[2:0] == 3'(NUM_AXES - 1))

	// The store is never written while a burst reads it.
	`IBPR_ASSERT_IMPLY(a_no_write_in_burst, clk, arst_n, emit_q, !pwrite)

	// Closing byte of a frame always starts a burst.
	`IBPR_ASSERT_NEXT(a_end_starts_burst, clk, arst_n, frame_end, emit_q && k_q == 3'd0)

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for imu_binary_packet_receiver: a table of directed frames, then random
// frames, with a bit-exact deframer and scaling predictor. Depends on ibpr_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
	import ibpr_pkg::*;

	localparam int TIMEOUT_CYCLES = 400000;
	localparam int IDLE_PCT       = 37;

	typedef enum {FK_GOOD, FK_BAD_SYNC, FK_BAD_CRC, FK_BAD_BOTH, FK_RESTART, FK_STRAY} frame_kind_t;

	// One output word as the block should present it.
	typedef struct packed {
		logic [2:0]  axis;
		logic [15:0] value;
		status_t     status;
		logic        last;
	} sample_t;

	// One directed frame. Words are in axis order: gyro x,y,z then accel x,y,z.
	typedef struct {
		frame_kind_t kind;
		bit          set_gains;
		logic [31:0] gyro_g;
		logic [31:0] accel_g;
		logic [31:0] words [6];
		bit          typed;
		status_t     want_status;
		logic [15:0] want_vals [6];
	} frame_row_t;

	frame_row_t dir_rows [13] = '{
		// Ordinary values at the reset gains.
		'{FK_GOOD, 1'b0, 32'h0, 32'h0,
			'{32'h3F800000, 32'hC0200000, 32'h3C23D70A, 32'h411CF5C3, 32'hC11CF5C3, 32'h3F000000},
			1'b0, ST_GOOD, '{default: 16'h0}},
		// Every kind of NaN gives zero.
		'{FK_GOOD, 1'b0, 32'h0, 32'h0,
			'{32'h7FC00000, 32'hFFC00000, 32'h7F800001, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'hFF800001},
			1'b1, ST_GOOD, '{default: 16'h0}},
		// Infinities saturate by sign.
		'{FK_GOOD, 1'b0, 32'h0, 32'h0,
			'{32'h7F800000, 32'hFF800000, 32'h7F800000, 32'hFF800000, 32'h7F800000, 32'hFF800000},
			1'b1, ST_GOOD, '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}},
		// Largest finite values, signed zeros and subnormals.
		'{FK_GOOD, 1'b0, 32'h0, 32'h0,
			'{32'h7F7FFFFF, 32'hFF7FFFFF, 32'h00000000, 32'h80000000, 32'h00000001, 32'h807FFFFF},
			1'b1, ST_GOOD, '{16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}},
		'{FK_BAD_SYNC, 1'b0, 32'h0, 32'h0, '{default: 32'h3F800000},
			1'b1, ST_SYNC_ERR, '{default: 16'h0}},
		'{FK_BAD_CRC, 1'b0, 32'h0, 32'h0, '{default: 32'h3F800000},
			1'b1, ST_CRC_ERR, '{default: 16'h0}},
		// Both checks fail: the sync error is reported.
		'{FK_BAD_BOTH, 1'b0, 32'h0, 32'h0, '{default: 32'h3F800000},
			1'b1, ST_SYNC_ERR, '{default: 16'h0}},
		// Noise outside a frame, then a frame.
		'{FK_STRAY, 1'b0, 32'h0, 32'h0,
			'{32'h40490FDB, 32'hC0490FDB, 32'h3E800000, 32'hBE800000, 32'h42C80000, 32'hC2C80000},
			1'b0, ST_GOOD, '{default: 16'h0}},
		// A frame cut short by a new frame start.
		'{FK_RESTART, 1'b0, 32'h0, 32'h0,
			'{32'h3DCCCCCD, 32'hBDCCCCCD, 32'h41200000, 32'hC1200000, 32'h3F800000, 32'hBF800000},
			1'b0, ST_GOOD, '{default: 16'h0}},
		// Zero gain: infinities and large values give zero too.
		'{FK_GOOD, 1'b1, 32'h0, 32'h0,
			'{32'h7F800000, 32'hFF800000, 32'h3F800000, 32'h7F7FFFFF, 32'hFF7FFFFF, 32'hC0000000},
			1'b1, ST_GOOD, '{default: 16'h0}},
		// Largest gain with small values.
		'{FK_GOOD, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF,
			'{32'h3F800000, 32'hBF800000, 32'h3A800000, 32'h00800000, 32'h358637BD, 32'h34000000},
			1'b0, ST_GOOD, '{default: 16'h0}},
		// Unit gain: truncation and both saturation edges.
		'{FK_GOOD, 1'b1, 32'h00010000, 32'h00010000,
			'{32'h46FFFE00, 32'hC7000000, 32'h47000000, 32'hC7000100, 32'h3FFFFFFF, 32'hBFFFFFFF},
			1'b1, ST_GOOD, '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF}},
		'{FK_GOOD, 1'b1, GYRO_GAIN_RST, ACCEL_GAIN_RST,
			'{32'h3F000000, 32'hBF400000, 32'h3E4CCCCD, 32'h40800000, 32'hC0800000, 32'h3F99999A},
			1'b0, ST_GOOD, '{default: 16'h0}}
	};

	logic        clk;
	logic        arst_n          = 1'b0;
	logic        cfg_valid       = 1'b0;
	logic        cfg_ready;
	logic        cfg_index       = 1'b0;
	logic [31:0] cfg_data        = 32'h0;
	logic        s_axis_tvalid   = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata    = 8'h0;
	logic        s_axis_tuser    = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready   = 1'b0;
	logic [23:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	// Predictor state, mirroring the block.
	logic [31:0] gyro_gain_q  = GYRO_GAIN_RST;
	logic [31:0] accel_gain_q = ACCEL_GAIN_RST;
	bit          frm_open     = 1'b0;
	int          frm_idx      = 0;
	logic [15:0] frm_crc      = 16'h0;
	bit          frm_sync_ok  = 1'b0;
	logic [7:0]  payload [PAYLOAD_BYTES];

	sample_t     pending_samples [$];
	sample_t     typed_words [$];
	int          fail_count      = 0;
	int          cycle_count     = 0;
	bit          calm            = 1'b0;

	imu_binary_packet_receiver dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// CRC-16, polynomial 0x1021, one bit at a time, MSB first.
	function automatic logic [15:0] crc16_step(input logic [15:0] c_in, input logic [7:0] b);
		logic [15:0] c;
		int i;
		c = c_in ^ {b, 8'h00};
		for (i = 0; i < 8; i++)
			c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
		return c;
	endfunction

	// Single float times a Q16.16 gain, truncated toward zero, saturated to int16.
	function automatic logic [15:0] scale_to_i16(input logic [31:0] f, input logic [31:0] gain);
		logic [7:0]  ex;
		logic [23:0] man;
		logic [55:0] prod;
		logic [63:0] mag;
		int sh;
		ex  = f[30:23];
		man = {1'b0, f[22:0]};
		if (ex == 8'hFF) begin
			if (f[22:0] != 23'h0 || gain == 32'h0)
				return 16'h0000;
			return f[31] ? 16'h8000 : 16'h7FFF;
		end
		if (ex == 8'h00)
			ex = 8'd1;
		else
			man[23] = 1'b1;
		prod = man * gain;
		sh   = int'(ex) - int'(EXP_SHIFT_BASE);
		if (prod == 56'h0)
			mag = 64'h0;
		else if (sh >= 0)
			mag = (prod > 56'hFFFF || sh >= 16) ? 64'h10000 : (64'(prod) << sh);
		else if (sh <= -64)
			mag = 64'h0;
		else
			mag = 64'(prod) >> (-sh);
		if (f[31])
			return (mag >= 64'h8000) ? 16'h8000 : 16'(64'h10000 - mag);
		return (mag > 64'h7FFF) ? 16'h7FFF : mag[15:0];
	endfunction

	// Advance the predicted deframer by one accepted byte and queue the words it causes.
	task automatic deframe_byte(input logic [7:0] b, input logic st);
		int k;
		int off;
		logic [31:0] w;
		if (st) begin
			frm_open    = 1'b1;
			frm_idx     = 1;
			frm_crc     = 16'h0;
			frm_sync_ok = (b == SYNC_VALUE);
			return;
		end
		if (!frm_open)
			return;
		frm_crc = crc16_step(frm_crc, b);
		if (frm_idx >= PAYLOAD_FIRST && frm_idx < PAYLOAD_FIRST + PAYLOAD_BYTES)
			payload[frm_idx - PAYLOAD_FIRST] = b;
		if (frm_idx + 1 < FRAME_BYTES) begin
			frm_idx++;
			return;
		end
		frm_open = 1'b0;
		frm_idx  = 0;
		if (typed_words.size() != 0) begin
			pending_samples = {pending_samples, typed_words};
			typed_words.delete();
		end else if (!frm_sync_ok || frm_crc != 16'h0) begin
			pending_samples.push_back('{3'd0, 16'h0, frm_sync_ok ? ST_CRC_ERR : ST_SYNC_ERR, 1'b1});
		end else begin
			for (k = 0; k < NUM_AXES; k++) begin
				off = (k < 3) ? 12 + 4 * k : 4 * (k - 3);
				w   = {payload[off + 3], payload[off + 2], payload[off + 1], payload[off]};
				pending_samples.push_back('{3'(k),
					scale_to_i16(w, (k < 3) ? gyro_gain_q : accel_gain_q), ST_GOOD, k == 5});
			end
		end
	endtask

	// Offer one byte, with random idle cycles first, and return at the edge that takes it.
	task automatic push_byte(input logic [7:0] b, input logic st);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= st;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		deframe_byte(b, st);
	endtask

	// Write a gain register once the block has gone quiet.
	task automatic write_gain(input logic idx, input logic [31:0] val);
		s_axis_tvalid <= 1'b0;
		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_GYRO_GAIN)
			gyro_gain_q = val;
		else
			accel_gain_q = val;
	endtask

	// Build and send one frame, with stray bytes or a cut-off frame ahead of it where asked.
	task automatic run_frame(input frame_kind_t kind, input logic [31:0] w [6]);
		logic [7:0]  fb [FRAME_BYTES];
		logic [15:0] crc;
		int i;
		int j;
		int n;
		if (kind == FK_STRAY) begin
			n = $urandom_range(1, 6);
			repeat (n) push_byte(8'($urandom), 1'b0);
		end
		if (kind == FK_RESTART) begin
			n = $urandom_range(1, FRAME_BYTES - 1);
			for (i = 0; i < n; i++)
				push_byte((i == 0) ? SYNC_VALUE : 8'($urandom), i == 0);
		end
		fb[0] = SYNC_VALUE;
		for (i = 1; i < PAYLOAD_FIRST; i++)
			fb[i] = 8'($urandom);
		// Accel floats first in the payload, gyro floats after, each little-endian.
		for (i = 0; i < 3; i++) begin
			for (j = 0; j < 4; j++) begin
				fb[PAYLOAD_FIRST + 4 * i + j]      = w[3 + i][8 * j +: 8];
				fb[PAYLOAD_FIRST + 12 + 4 * i + j] = w[i][8 * j +: 8];
			end
		end
		crc = 16'h0;
		for (i = 1; i < FRAME_BYTES - 2; i++)
			crc = crc16_step(crc, fb[i]);
		fb[FRAME_BYTES - 2] = crc[15:8];
		fb[FRAME_BYTES - 1] = crc[7:0];
		if (kind == FK_BAD_SYNC || kind == FK_BAD_BOTH) begin
			n = $urandom_range(0, 254);
			fb[0] = (n >= SYNC_VALUE) ? 8'(n + 1) : 8'(n);
		end
		if (kind == FK_BAD_CRC || kind == FK_BAD_BOTH) begin
			n = $urandom_range(1, FRAME_BYTES - 1);
			fb[n] = fb[n] ^ 8'($urandom_range(1, 255));
		end
		for (i = 0; i < FRAME_BYTES; i++)
			push_byte(fb[i], i == 0);
	endtask

	// Mostly values that land inside the int16 range, with specials mixed in.
	function automatic logic [31:0] pick_float();
		logic [31:0] f;
		f = $urandom;
		case ($urandom_range(0, 19))
			0: begin
				f[30:23] = 8'hFF;
				if ($urandom_range(0, 1) == 0)
					f[22:0] = 23'h0;
			end
			1: f[30:23] = 8'h00;
			2: ;
			default: f[30:23] = 8'($urandom_range(112, 150));
		endcase
		return f;
	endfunction

	function automatic logic [31:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return 32'h0;
			1: return 32'hFFFFFFFF;
			2: return $urandom;
			default: return $urandom_range(32'h00010000, 32'h10000000);
		endcase
	endfunction

	// Sink side: random back-pressure except during the calm stretch.
	always @(posedge clk)
		m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

	// Compare every accepted word with the oldest expectation.
	always @(posedge clk) begin : check_words
		sample_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_samples.size() == 0) begin
				$display("%0t: word with none expected: axis %0d value %h status %0d last %b",
					$time, m_axis_tdata[2:0], m_axis_tdata[18:3], m_axis_tuser, m_axis_tlast);
				fail_count++;
			end else begin
				want = pending_samples.pop_front();
				if (m_axis_tdata[2:0] !== want.axis) begin
					$display("%0t: axis expected %0d actual %0d", $time, want.axis,
						m_axis_tdata[2:0]);
					fail_count++;
				end
				if (m_axis_tdata[18:3] !== want.value) begin
					$display("%0t: value (axis %0d) expected %h actual %h", $time, want.axis,
						want.value, m_axis_tdata[18:3]);
					fail_count++;
				end
				if (m_axis_tuser !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status,
						m_axis_tuser);
					fail_count++;
				end
				if (m_axis_tlast !== want.last) begin
					$display("%0t: last (axis %0d) expected %b actual %b", $time, want.axis,
						want.last, m_axis_tlast);
					fail_count++;
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > TIMEOUT_CYCLES) begin
			$display("imu_binary_packet_receiver: mismatch");
			$finish;
		end
	end

	// Stimulus: directed frames, then random frames under changing gains.
	initial begin : stimulus
		int r;
		int k;
		int frames;
		int rand_bytes;
		logic [31:0] w [6];
		frame_kind_t kind;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < $size(dir_rows); r++) begin
			if (dir_rows[r].set_gains) begin
				write_gain(CFG_GYRO_GAIN, dir_rows[r].gyro_g);
				write_gain(CFG_ACCEL_GAIN, dir_rows[r].accel_g);
			end
			if (dir_rows[r].typed) begin
				if (dir_rows[r].want_status != ST_GOOD)
					typed_words.push_back('{3'd0, 16'h0, dir_rows[r].want_status, 1'b1});
				else
					for (k = 0; k < NUM_AXES; k++)
						typed_words.push_back('{3'(k), dir_rows[r].want_vals[k], ST_GOOD, k == 5});
			end
			run_frame(dir_rows[r].kind, dir_rows[r].words);
		end

		frames     = 0;
		rand_bytes = 0;
		while (rand_bytes < 120) begin
			// Hold the sender until every word so far has been taken.
			if (frames == 3) begin
				s_axis_tvalid <= 1'b0;
				while (pending_samples.size() != 0)
					@(posedge clk);
			end
			if (frames % 3 == 0) begin
				write_gain(CFG_GYRO_GAIN, pick_gain());
				write_gain(CFG_ACCEL_GAIN, pick_gain());
			end
			calm = (frames >= 1 && frames < 3);
			r = $urandom_range(0, 99);
			if (r < 70)
				kind = FK_GOOD;
			else if (r < 78)
				kind = FK_BAD_SYNC;
			else if (r < 85)
				kind = FK_BAD_CRC;
			else if (r < 88)
				kind = FK_BAD_BOTH;
			else if (r < 94)
				kind = FK_RESTART;
			else
				kind = FK_STRAY;
			for (k = 0; k < NUM_AXES; k++)
				w[k] = pick_float();
			run_frame(kind, w);
			rand_bytes += FRAME_BYTES;
			frames++;
		end
		calm = 1'b0;

		s_axis_tvalid <= 1'b0;
		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("imu_binary_packet_receiver: match");
		else
			$display("imu_binary_packet_receiver: mismatch");
		$finish;
	end

endmodule
